// ===== rtl/core/v3a_pkg.sv =====
// shared types and constants for the three-lane vector alu
// used by v3a_lane, v3a_merge and integer_vec3_alu; no dependencies
package v3a_pkg;

    localparam int LANE_WIDTH_DEF = 32;
    localparam int FIELD_W        = 32;
    localparam int FUNC_W         = 4;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 4'd0,
        FUNC_SUB    = 4'd1,
        FUNC_MUL    = 4'd2,
        FUNC_DIV    = 4'd3,
        FUNC_MIN    = 4'd4,
        FUNC_MAX    = 4'd5,
        FUNC_DOT    = 4'd6,
        FUNC_CROSS  = 4'd7,
        FUNC_NEG    = 4'd8,
        FUNC_SUM    = 4'd9,
        FUNC_LENSQ  = 4'd10,
        FUNC_DISTSQ = 4'd11,
        FUNC_EQ     = 4'd12
    } func_t;

    typedef struct packed {
        logic eq;
        logic dz;
    } lane_flag_t;

endpackage

// ===== rtl/core/v3a_lane.sv =====
// one lane of the vector alu: elementwise ops, two multipliers and a
// one-bit-per-stage pipelined signed divider; depends on v3a_pkg
module v3a_lane #(
    parameter int LW = v3a_pkg::LANE_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 en,
    input  v3a_pkg::func_t       func,
    input  logic [LW-1:0]        a,
    input  logic [LW-1:0]        b,
    input  logic [LW-1:0]        ca,
    input  logic [LW-1:0]        cb,
    input  logic [LW-1:0]        cc,
    input  logic [LW-1:0]        cd,
    output logic [LW-1:0]        vec,
    output logic [LW-1:0]        prod_p,
    output logic [LW-1:0]        prod_q,
    output logic [LW-1:0]        quot,
    output v3a_pkg::lane_flag_t  flag
);
    import v3a_pkg::*;

    logic [LW-1:0]   diff, sum, neg, vec_c, m1, m2, one, ma, mb;
    logic [2*LW-1:0] pf, qf;
    lane_flag_t      flag_c;

    logic [LW-1:0]   vec_reg  [0:LW];
    logic [LW-1:0]   p_reg    [0:LW];
    logic [LW-1:0]   q_reg    [0:LW];
    lane_flag_t      flag_reg [0:LW];
    logic [LW-1:0]   rem_reg  [0:LW];
    logic [LW-1:0]   aq_reg   [0:LW];
    logic [LW-1:0]   dv_reg   [0:LW];
    logic            sgn_reg  [0:LW];
    logic            bz_reg   [0:LW];
    logic [LW-1:0]   rem_next [0:LW-1];
    logic [LW-1:0]   aq_next  [0:LW-1];

    assign diff = a - b;
    assign sum  = a + b;
    assign neg  = '0 - a;
    assign one  = {{(LW-1){1'b0}}, 1'b1};
    assign ma   = a[LW-1] ? neg : a;
    assign mb   = b[LW-1] ? ('0 - b) : b;

    always_comb
    begin
        unique case (func)
            FUNC_ADD: vec_c = sum;
            FUNC_SUB: vec_c = diff;
            FUNC_MIN: vec_c = ($signed(b) < $signed(a)) ? b : a;
            FUNC_MAX: vec_c = ($signed(a) < $signed(b)) ? b : a;
            FUNC_NEG: vec_c = neg;
            default:  vec_c = '0;
        endcase
    end

    always_comb
    begin
        unique case (func)
            FUNC_MUL, FUNC_DOT:
            begin
                m1 = a;
                m2 = b;
            end
            FUNC_LENSQ:
            begin
                m1 = a;
                m2 = a;
            end
            FUNC_DISTSQ:
            begin
                m1 = diff;
                m2 = diff;
            end
            FUNC_CROSS:
            begin
                m1 = ca;
                m2 = cb;
            end
            FUNC_SUM:
            begin
                m1 = a;
                m2 = one;
            end
            default:
            begin
                m1 = '0;
                m2 = '0;
            end
        endcase
    end

    assign pf = m1 * m2;
    assign qf = cc * cd;

    assign flag_c.eq = (a == b);
    assign flag_c.dz = (func == FUNC_DIV) && (b == '0);

    // restoring divide, one quotient bit per stage
    for (genvar k = 0; k < LW; k++)
    begin : g_div
        logic [LW:0] t, tr;
        logic        ge;
        always_comb
        begin
            t            = {rem_reg[k], aq_reg[k][LW-1]};
            ge           = (t >= {1'b0, dv_reg[k]});
            tr           = ge ? (t - {1'b0, dv_reg[k]}) : t;
            rem_next[k]  = tr[LW-1:0];
            aq_next[k]   = {aq_reg[k][LW-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg[0]  <= vec_c;
            p_reg[0]    <= pf[LW-1:0];
            q_reg[0]    <= qf[LW-1:0];
            flag_reg[0] <= flag_c;
            rem_reg[0]  <= '0;
            aq_reg[0]   <= ma;
            dv_reg[0]   <= mb;
            sgn_reg[0]  <= a[LW-1] ^ b[LW-1];
            bz_reg[0]   <= (b == '0);
            for (int k = 0; k < LW; k++)
            begin
                vec_reg[k+1]  <= vec_reg[k];
                p_reg[k+1]    <= p_reg[k];
                q_reg[k+1]    <= q_reg[k];
                flag_reg[k+1] <= flag_reg[k];
                rem_reg[k+1]  <= rem_next[k];
                aq_reg[k+1]   <= aq_next[k];
                dv_reg[k+1]   <= dv_reg[k];
                sgn_reg[k+1]  <= sgn_reg[k];
                bz_reg[k+1]   <= bz_reg[k];
            end
        end
    end

    assign vec    = vec_reg[LW];
    assign prod_p = p_reg[LW];
    assign prod_q = q_reg[LW];
    assign flag   = flag_reg[LW];
    assign quot   = bz_reg[LW] ? '0 : (sgn_reg[LW] ? ('0 - aq_reg[LW]) : aq_reg[LW]);

endmodule

// ===== rtl/core/v3a_merge.sv =====
// merge stage: picks lane results, forms cross, scalar sums and flags
// into the output register; depends on v3a_pkg
module v3a_merge #(
    parameter int LW = v3a_pkg::LANE_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      en,
    input  v3a_pkg::func_t            func,
    input  logic [2:0][LW-1:0]        vec,
    input  logic [2:0][LW-1:0]        prod_p,
    input  logic [2:0][LW-1:0]        prod_q,
    input  logic [2:0][LW-1:0]        quot,
    input  v3a_pkg::lane_flag_t [2:0] flag,
    output logic [2:0][LW-1:0]        r,
    output logic [LW-1:0]             scalar,
    output logic                      is_equal,
    output logic                      div_zero
);
    import v3a_pkg::*;

    logic [2:0][LW-1:0] r_next;
    logic [LW-1:0]      scalar_next;
    logic               eq_next, dz_next;
    logic [2:0][LW-1:0] r_reg;
    logic [LW-1:0]      scalar_reg;
    logic               eq_reg, dz_reg;

    always_comb
    begin
        r_next      = '0;
        scalar_next = '0;
        eq_next     = 1'b0;
        dz_next     = 1'b0;
        unique case (func)
            FUNC_ADD, FUNC_SUB, FUNC_MIN, FUNC_MAX, FUNC_NEG:
                r_next = vec;
            FUNC_MUL:
                r_next = prod_p;
            FUNC_DIV:
            begin
                r_next  = quot;
                dz_next = flag[0].dz | flag[1].dz | flag[2].dz;
            end
            FUNC_CROSS:
                for (int i = 0; i < 3; i++)
                    r_next[i] = prod_p[i] - prod_q[i];
            FUNC_DOT, FUNC_SUM, FUNC_LENSQ, FUNC_DISTSQ:
                scalar_next = prod_p[0] + prod_p[1] + prod_p[2];
            FUNC_EQ:
                eq_next = flag[0].eq & flag[1].eq & flag[2].eq;
            default:
                r_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg      <= r_next;
            scalar_reg <= scalar_next;
            eq_reg     <= eq_next;
            dz_reg     <= dz_next;
        end
    end

    assign r        = r_reg;
    assign scalar   = scalar_reg;
    assign is_equal = eq_reg;
    assign div_zero = dz_reg;

endmodule

// ===== rtl/core/integer_vec3_alu.sv =====
// three-lane signed vector alu, top level; instantiates v3a_lane and v3a_merge
// each request passes the input register, the lane pipeline with its one-bit-per-stage
// divider and the merge output register; throughput one request per cycle when not stalled
// the whole pipeline holds while a finished result waits at the output
// rst_n clears the valid bits only; the data registers are not reset and need no clearing
module integer_vec3_alu #(
    parameter int LANE_WIDTH = v3a_pkg::LANE_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z
    input  logic [3:0]   s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // r_x, r_y, r_z, scalar_out
    output logic [1:0]   m_tuser    // is_equal, div_zero
);
    import v3a_pkg::*;

    localparam int LW   = LANE_WIDTH;
    localparam int PIPE = LW + 3;

    logic                en;
    logic [PIPE-1:0]     v_reg;
    func_t               func_reg [0:LW+1];
    logic [2:0][LW-1:0]  a_reg, b_reg;
    logic [2:0][LW-1:0]  a_in, b_in;
    logic [2:0][LW-1:0]  vec, pp, pq, quot, r;
    lane_flag_t [2:0]    flag;
    logic [LW-1:0]       scalar;
    logic                is_equal, div_zero;
    logic [3:0][FIELD_W-1:0] out_w;

    assign en       = ~v_reg[PIPE-1] | m_tready;
    assign s_tready = en;
    assign m_tvalid = v_reg[PIPE-1];

    for (genvar i = 0; i < 3; i++)
    begin : g_in
        if (LW > FIELD_W)
        begin : g_wide
            assign a_in[i] = {{(LW-FIELD_W){s_tdata[FIELD_W*i+FIELD_W-1]}},
                              s_tdata[FIELD_W*i +: FIELD_W]};
            assign b_in[i] = {{(LW-FIELD_W){s_tdata[FIELD_W*(i+3)+FIELD_W-1]}},
                              s_tdata[FIELD_W*(i+3) +: FIELD_W]};
        end
        else
        begin : g_narrow
            assign a_in[i] = s_tdata[FIELD_W*i +: LW];
            assign b_in[i] = s_tdata[FIELD_W*(i+3) +: LW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[PIPE-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg       <= a_in;
            b_reg       <= b_in;
            func_reg[0] <= func_t'(s_tuser);
            for (int k = 0; k <= LW; k++)
                func_reg[k+1] <= func_reg[k];
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        v3a_lane #(.LW(LW)) u_lane (
            .clk    (clk),
            .en     (en),
            .func   (func_reg[0]),
            .a      (a_reg[i]),
            .b      (b_reg[i]),
            .ca     (a_reg[(i+1)%3]),
            .cb     (b_reg[(i+2)%3]),
            .cc     (a_reg[(i+2)%3]),
            .cd     (b_reg[(i+1)%3]),
            .vec    (vec[i]),
            .prod_p (pp[i]),
            .prod_q (pq[i]),
            .quot   (quot[i]),
            .flag   (flag[i])
        );
    end

    v3a_merge #(.LW(LW)) u_merge (
        .clk      (clk),
        .en       (en),
        .func     (func_reg[LW+1]),
        .vec      (vec),
        .prod_p   (pp),
        .prod_q   (pq),
        .quot     (quot),
        .flag     (flag),
        .r        (r),
        .scalar   (scalar),
        .is_equal (is_equal),
        .div_zero (div_zero)
    );

    for (genvar i = 0; i < 4; i++)
    begin : g_out
        logic [LW-1:0] x;
        assign x = (i == 3) ? scalar : r[i%3];
        if (LW >= FIELD_W)
        begin : g_wide
            assign out_w[i] = x[FIELD_W-1:0];
        end
        else
        begin : g_narrow
            assign out_w[i] = {{(FIELD_W-LW){x[LW-1]}}, x};
        end
    end

    assign m_tdata = out_w;
    assign m_tuser = {div_zero, is_equal};

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("is_equal and div_zero both set");

    a_eq_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("eq result carries data");

    a_dz_no_scalar: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[127:96] == '0))
        else $error("divide result carries scalar");

    a_valid_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(v_reg[PIPE-2]))
        else $error("output valid without item in last stage");

endmodule
